/* hw/rtl/ssg_pkg.sv */
// shared types, constants and helper functions for the sum-of-sines pattern generator
// no dependencies; compiled before every other file of the block
package ssg_pkg;

  localparam int MAX_TERMS    = 4;
  localparam int FREQ_OCTAVES = 4;
  localparam int GAIN_DEPTH   = 3 * MAX_TERMS + 1;
  localparam int GAIN_IDX_W   = $clog2(GAIN_DEPTH);
  localparam int TERM_IDX_W   = $clog2(MAX_TERMS);
  localparam int TCNT_W       = $clog2(MAX_TERMS + 1);

  localparam int COEF_W     = 16;
  localparam int TIME_W     = 32;
  localparam int TERM_W     = 3 * COEF_W;
  localparam int PC_W       = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TERM_W;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_PARAM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM0       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM2       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM3       = 3'd5;

  // word operations
  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_GAIN = 1'b1;

  localparam logic signed [15:0] GAIN_ONE = 16'sd4096;

  // fixed-point constants
  localparam logic [31:0]        ONE_Q30     = 32'd1 << 30;
  localparam logic [29:0]        LN2_Q30     = 30'd744261118;
  localparam logic [63:0]        FREQ_MUL    = 64'(FREQ_OCTAVES) * 64'd891723283;
  localparam logic signed [63:0] LOG2_2PI    = 64'sd711755573;
  localparam logic [30:0]        HALFPI_Q30  = 31'd1686629713;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_FREQ,
    ST_LOGU,
    ST_POWM,
    ST_POWD,
    ST_ANGLE,
    ST_SINZ,
    ST_SINZ2,
    ST_SINM,
    ST_SIND,
    ST_SINS,
    ST_ACC,
    ST_FINAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [31:0] b;
    logic [5:0]  nbits;
    logic        b_signed;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [6:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [6:0]  remainder;
  } div_rsp_t;

  typedef struct packed {
    logic              ok;
    logic [TCNT_W-1:0] terms;
  } term_cnt_t;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7fff;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // taylor divisors of the sine polynomial, highest-order term first
  function automatic logic [6:0] sine_div(input logic [2:0] idx);
    logic [6:0] d;
    unique case (idx)
      3'd0:    d = 7'd110;
      3'd1:    d = 7'd72;
      3'd2:    d = 7'd42;
      3'd3:    d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  // only counts of the form 3t+1 are usable
  function automatic term_cnt_t term_lookup(input logic [PC_W-1:0] pc);
    term_cnt_t r;
    r.ok    = 1'b1;
    r.terms = '0;
    unique case (pc)
      4'd1:    r.terms = TCNT_W'(0);
      4'd4:    r.terms = TCNT_W'(1);
      4'd7:    r.terms = TCNT_W'(2);
      4'd10:   r.terms = TCNT_W'(3);
      4'd13:   r.terms = TCNT_W'(4);
      default: r.ok = 1'b0;
    endcase
    if (int'(r.terms) > MAX_TERMS) r.ok = 1'b0;
    return r;
  endfunction

endpackage

/* hw/rtl/ssg_in_if.sv */
// input channel of the pattern generator: evaluate and gain-write words
// depends on ssg_pkg
interface ssg_in_if;
  import ssg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [TIME_W-1:0]        time_value;
  logic [3:0]               gain_index;
  logic signed [COEF_W-1:0] gain_value;
  modport source (output valid, operation, time_value, gain_index, gain_value, input ready);
  modport sink   (input valid, operation, time_value, gain_index, gain_value, output ready);
endinterface

/* hw/rtl/ssg_out_if.sv */
// output channel of the pattern generator: one pattern word per evaluate
// depends on ssg_pkg
interface ssg_out_if;
  import ssg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] pattern_value;
  modport source (output valid, pattern_value, input ready);
  modport sink   (input valid, pattern_value, output ready);
endinterface

/* hw/rtl/ssg_mul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on ssg_pkg
module ssg_mul (
  input  logic              clk,
  input  logic              rst,
  input  ssg_pkg::mul_req_t req,
  output logic              done,
  output logic [63:0]       acc
);
  import ssg_pkg::*;

  logic        running;
  logic [5:0]  cnt;
  logic [63:0] a;
  logic [31:0] b;
  logic        b_signed;
  logic [63:0] addend;

  // top bit of a signed multiplier carries negative weight
  always_comb begin
    addend = '0;
    if (b[0]) addend = (b_signed && cnt == 6'd1) ? (64'd0 - a) : a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && cnt == 6'd1;
      if (req.start) running <= 1'b1;
      else if (running && cnt == 6'd1) running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc      <= '0;
      a        <= req.a;
      b        <= req.b;
      cnt      <= req.nbits;
      b_signed <= req.b_signed;
    end else if (running) begin
      acc <= acc + addend;
      a   <= {a[62:0], 1'b0};
      b   <= {1'b0, b[31:1]};
      cnt <= cnt - 6'd1;
    end
  end

endmodule

/* hw/rtl/ssg_div.sv */
// restoring divider, 32-bit dividend by a small divisor, one quotient bit per cycle
// depends on ssg_pkg
module ssg_div (
  input  logic              clk,
  input  logic              rst,
  input  ssg_pkg::div_req_t req,
  output ssg_pkg::div_rsp_t rsp
);
  import ssg_pkg::*;

  logic        running;
  logic [5:0]  cnt;
  logic [31:0] dq;
  logic [6:0]  rem;
  logic [6:0]  dvs;
  logic [7:0]  trial;
  logic        qbit;

  always_comb begin
    trial = {rem, dq[31]};
    qbit  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= running && cnt == 6'd1;
      if (req.start) running <= 1'b1;
      else if (running && cnt == 6'd1) running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      cnt <= 6'd32;
    end else if (running) begin
      rem <= qbit ? 7'(trial - {1'b0, dvs}) : trial[6:0];
      dq  <= {dq[30:0], qbit};
      cnt <= cnt - 6'd1;
    end
  end

  assign rsp.quotient  = dq;
  assign rsp.remainder = rem;

endmodule

/* hw/rtl/sum_of_sines_pattern_generator_core.sv */
// sum-of-sines drive-pattern generator, top level
// depends on ssg_pkg, ssg_in_if, ssg_out_if, ssg_mul, ssg_div
//
// usage
//   in_ch carries one word at a time: an evaluate word (operation 0) with a time value,
//   or a gain-write word (operation 1) that replaces one feedback gain
//   out_ch gives one pattern word for each evaluate word, none for gain writes
//   cfg_we/cfg_index/cfg_data write the registers (count, offset, four term words);
//   any write to a listed register puts every feedback gain back to 1.0
// timing
//   one word is worked on at a time; in_ch.ready is high only while the sequencer idles
//   a gain write leaves the sequencer idle; an evaluate takes longer with each active term,
//   set by the shared bit-serial multiplier (one bit a cycle) and the restoring divider
//   that the power and sine series run through
//   an evaluate with an unusable count answers 0 without running the series
// reset
//   synchronous, active high: count 1, offset and terms 0, all gains 1.0, no word held
// back-pressure
//   the result sits in an output register; a new word is taken while it waits,
//   and the sequencer only holds at the end of the next evaluate if it is still unread
module sum_of_sines_pattern_generator_core (
  input  logic                           clk,
  input  logic                           rst,
  ssg_in_if.sink                         in_ch,
  ssg_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ssg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssg_pkg::*;

  // control and configuration
  state_t                   state, state_next;
  logic                     launched;
  logic [PC_W-1:0]          param_count;
  logic signed [COEF_W-1:0] offset_coef;
  logic [TERM_W-1:0]        term_coefs [MAX_TERMS];
  logic signed [COEF_W-1:0] gain_store [GAIN_DEPTH];
  logic                     out_valid;
  logic signed [COEF_W-1:0] out_data;

  // working registers of one evaluate
  logic [TIME_W-1:0]        in_time;
  logic [TCNT_W-1:0]        terms;
  logic [TCNT_W-1:0]        t;
  logic [1:0]               j;
  logic [GAIN_IDX_W-1:0]    coef_idx;
  logic signed [COEF_W-1:0] amp, fex, pha;
  logic signed [63:0]       sum;
  logic [27:0]              r;
  logic signed [7:0]        n;
  logic [29:0]              u;
  logic [31:0]              p;
  logic [2:0]               k;
  logic [31:0]              v;
  logic [1:0]               quad;
  logic [30:0]              w;
  logic [30:0]              z;
  logic [31:0]              z2;
  logic [30:0]              h;
  logic [2:0]               d_idx;
  logic signed [31:0]       s;
  logic signed [COEF_W-1:0] res;

  // shared units
  mul_req_t    mreq;
  logic        mul_done;
  logic [63:0] mul_acc;
  div_req_t    dreq;
  div_rsp_t    drsp;

  ssg_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mul_done), .acc(mul_acc));
  ssg_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic      in_take;
  term_cnt_t tc;
  logic      is_mul_state, is_div_state, unit_done;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign tc          = term_lookup(param_count);

  assign is_mul_state = state == ST_SCALE || state == ST_FREQ || state == ST_LOGU ||
                        state == ST_POWM || state == ST_ANGLE || state == ST_SINZ ||
                        state == ST_SINZ2 || state == ST_SINM || state == ST_SINS ||
                        state == ST_ACC;
  assign is_div_state = state == ST_POWD || state == ST_SIND || state == ST_FINAL;
  assign unit_done    = (is_mul_state && mul_done) || (is_div_state && drsp.done);

  // datapath helpers
  logic signed [COEF_W-1:0] coef_cur;
  logic signed [COEF_W-1:0] gain_cur;
  logic signed [COEF_W-1:0] scale_res;
  logic signed [63:0]       y;
  logic signed [7:0]        shamt;
  logic [7:0]               shneg;
  logic [63:0]              f;
  logic [31:0]              angle;
  logic [30:0]              sv;
  logic signed [63:0]       xq;
  logic [31:0]              xmag;
  logic signed [63:0]       q64;
  logic signed [63:0]       qs;

  always_comb begin
    coef_cur = offset_coef;
    if (coef_idx != '0) begin
      unique case (j)
        2'd0:    coef_cur = term_coefs[t[TERM_IDX_W-1:0]][15:0];
        2'd1:    coef_cur = term_coefs[t[TERM_IDX_W-1:0]][31:16];
        default: coef_cur = term_coefs[t[TERM_IDX_W-1:0]][47:32];
      endcase
    end
  end

  assign gain_cur  = gain_store[coef_idx];
  assign scale_res = sat16($signed(mul_acc) >>> 12);
  assign y         = ($signed(mul_acc) >>> 16) - LOG2_2PI;

  // frequency: 2^r scaled by 2^(n+2), left shift capped at 32
  assign shamt = n + 8'sd2;
  assign shneg = 8'(-shamt);
  always_comb begin
    if (shamt >= 8'sd0) begin
      if (shamt > 8'sd32) f = {32'd0, p} << 32;
      else                f = {32'd0, p} << shamt[5:0];
    end else if (shneg >= 8'd63) begin
      f = '0;
    end else begin
      f = {32'd0, p} >> shneg[5:0];
    end
  end

  assign angle = mul_acc[47:16] + {pha, 16'd0};
  assign sv    = (mul_acc[60:30] > 31'(ONE_Q30)) ? 31'(ONE_Q30) : mul_acc[60:30];

  // final floor division of the Q15 sum by the term count plus one
  assign xq   = sum >>> 30;
  assign xmag = sum[63] ? 32'(-xq) : 32'(xq);
  assign q64  = 64'(drsp.quotient);
  always_comb begin
    if (!sum[63])                 qs = q64;
    else if (drsp.remainder != 0) qs = -(q64 + 64'sd1);
    else                          qs = -q64;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_take && in_ch.operation == OP_EVAL)
                  state_next = tc.ok ? ST_SCALE : ST_OUT;
      ST_SCALE: if (mul_done) begin
                  if (coef_idx == '0) state_next = (terms == '0) ? ST_FINAL : ST_SCALE;
                  else if (j == 2'd2) state_next = ST_FREQ;
                end
      ST_FREQ:  if (mul_done) state_next = ST_LOGU;
      ST_LOGU:  if (mul_done) state_next = ST_POWM;
      ST_POWM:  if (mul_done) state_next = ST_POWD;
      ST_POWD:  if (drsp.done) state_next = (k == 3'd1) ? ST_ANGLE : ST_POWM;
      ST_ANGLE: if (mul_done) state_next = ST_SINZ;
      ST_SINZ:  if (mul_done) state_next = ST_SINZ2;
      ST_SINZ2: if (mul_done) state_next = ST_SINM;
      ST_SINM:  if (mul_done) state_next = ST_SIND;
      ST_SIND:  if (drsp.done) state_next = (d_idx == 3'd4) ? ST_SINS : ST_SINM;
      ST_SINS:  if (mul_done) state_next = ST_ACC;
      ST_ACC:   if (mul_done)
                  state_next = (TCNT_W'(t + 1'b1) == terms) ? ST_FINAL : ST_SCALE;
      ST_FINAL: if (drsp.done) state_next = ST_OUT;
      ST_OUT:   if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // unit requests
  always_comb begin
    mreq          = '0;
    dreq          = '0;
    mreq.start    = is_mul_state && !launched;
    dreq.start    = is_div_state && !launched;
    unique case (state)
      ST_SCALE: begin
        mreq.a = 64'(coef_cur); mreq.b = 32'(gain_cur);
        mreq.nbits = 6'd16; mreq.b_signed = 1'b1;
      end
      ST_FREQ: begin
        mreq.a = FREQ_MUL; mreq.b = 32'(fex);
        mreq.nbits = 6'd16; mreq.b_signed = 1'b1;
      end
      ST_LOGU:  begin mreq.a = 64'(r); mreq.b = 32'(LN2_Q30); mreq.nbits = 6'd30; end
      ST_POWM:  begin mreq.a = 64'(p); mreq.b = 32'(u); mreq.nbits = 6'd30; end
      ST_POWD:  begin dreq.dividend = v; dreq.divisor = 7'(k); end
      ST_ANGLE: begin mreq.a = f; mreq.b = in_time; mreq.nbits = 6'd32; end
      ST_SINZ:  begin mreq.a = 64'(w); mreq.b = 32'(HALFPI_Q30); mreq.nbits = 6'd31; end
      ST_SINZ2: begin mreq.a = 64'(z); mreq.b = 32'(z); mreq.nbits = 6'd31; end
      ST_SINM:  begin mreq.a = 64'(h); mreq.b = z2; mreq.nbits = 6'd32; end
      ST_SIND:  begin dreq.dividend = v; dreq.divisor = sine_div(d_idx); end
      ST_SINS:  begin mreq.a = 64'(z); mreq.b = 32'(h); mreq.nbits = 6'd31; end
      ST_ACC: begin
        mreq.a = 64'(s); mreq.b = 32'(amp);
        mreq.nbits = 6'd16; mreq.b_signed = 1'b1;
      end
      ST_FINAL: begin dreq.dividend = xmag; dreq.divisor = 7'(terms) + 7'd1; end
      default: begin
        mreq.start = 1'b0;
        dreq.start = 1'b0;
      end
    endcase
  end

  // control, configuration and gains
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      launched    <= 1'b0;
      param_count <= PC_W'(1);
      offset_coef <= '0;
      for (int i = 0; i < MAX_TERMS; i++) term_coefs[i] <= '0;
      for (int i = 0; i < GAIN_DEPTH; i++) gain_store[i] <= GAIN_ONE;
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= (launched || mreq.start || dreq.start) && !unit_done;

      if (state == ST_OUT && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PARAM_COUNT: param_count   <= cfg_data[PC_W-1:0];
          CFG_OFFSET:      offset_coef   <= cfg_data[COEF_W-1:0];
          CFG_TERM0:       term_coefs[0] <= cfg_data;
          CFG_TERM1:       term_coefs[1] <= cfg_data;
          CFG_TERM2:       term_coefs[2] <= cfg_data;
          CFG_TERM3:       term_coefs[3] <= cfg_data;
          default: ;
        endcase
        if (cfg_index <= CFG_TERM3)
          for (int i = 0; i < GAIN_DEPTH; i++) gain_store[i] <= GAIN_ONE;
      end else if (in_take && in_ch.operation == OP_GAIN) begin
        // out-of-range indexes leave the store alone
        if (in_ch.gain_index < param_count && 32'(in_ch.gain_index) < GAIN_DEPTH)
          gain_store[in_ch.gain_index[GAIN_IDX_W-1:0]] <= in_ch.gain_value;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ch.ready)) out_data <= res;

    if (in_take) begin
      in_time  <= in_ch.time_value;
      terms    <= tc.terms;
      t        <= '0;
      j        <= '0;
      coef_idx <= '0;
      res      <= '0;
    end

    if (mul_done) begin
      unique case (state)
        ST_SCALE: begin
          coef_idx <= coef_idx + 1'b1;
          if (coef_idx == '0) begin
            sum <= 64'(scale_res) <<< 30;
          end else begin
            unique case (j)
              2'd0:    amp <= scale_res;
              2'd1:    fex <= scale_res;
              default: pha <= scale_res;
            endcase
            j <= (j == 2'd2) ? 2'd0 : j + 2'd1;
          end
        end
        ST_FREQ: begin
          r <= y[27:0];
          n <= y[35:28];
        end
        ST_LOGU: begin
          u <= mul_acc[57:28];
          p <= ONE_Q30;
          k <= 3'd7;
        end
        ST_POWM:  v <= mul_acc[61:30];
        ST_ANGLE: begin
          quad  <= angle[31:30];
          w     <= angle[30] ? 31'(ONE_Q30) - {1'b0, angle[29:0]} : {1'b0, angle[29:0]};
          h     <= 31'(ONE_Q30);
          d_idx <= '0;
        end
        ST_SINZ:  z  <= mul_acc[60:30];
        ST_SINZ2: z2 <= mul_acc[61:30];
        ST_SINM:  v  <= mul_acc[61:30];
        ST_SINS:  s  <= quad[1] ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
        ST_ACC: begin
          sum <= sum + $signed(mul_acc);
          t   <= t + 1'b1;
        end
        default: ;
      endcase
    end

    if (drsp.done) begin
      unique case (state)
        ST_POWD: begin
          p <= ONE_Q30 + drsp.quotient;
          k <= k - 3'd1;
        end
        ST_SIND: begin
          h     <= 31'(ONE_Q30) - drsp.quotient[30:0];
          d_idx <= d_idx + 3'd1;
        end
        ST_FINAL: res <= sat16(qs);
        default: ;
      endcase
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.pattern_value = out_data;

endmodule

/* tb/sv/tb_sum_of_sines_pattern_generator_core.sv */
// self-checking bench for the sum-of-sines pattern generator: a fixed-point predictor of the
// pattern value, random idling on both channels and register changes between phases
// depends on ssg_pkg, ssg_in_if, ssg_out_if and sum_of_sines_pattern_generator_core
module tb_sum_of_sines_pattern_generator_core;
  import ssg_pkg::*;

  // register index past the end of the map, a write there must leave the gains alone
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_TERM3 + 3'd1;
  localparam longint LOG2_10_Q28  = 64'sd891723283;
  localparam longint LOG2_2PI_Q28 = 64'sd711755573;
  localparam longint LN2_Q30_L    = 64'sd744261118;
  localparam longint HALF_PI_Q30  = 64'sd1686629713;
  localparam longint UNITY_Q30    = 64'sd1 << 30;
  localparam int     N_RANDOM     = 1400;
  localparam longint CYCLE_LIMIT  = 64'd24_000_000;
  localparam int     LONG_HOLD    = 9000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ssg_in_if  in_ch ();
  ssg_out_if out_ch ();

  sum_of_sines_pattern_generator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // one pending input word
  typedef struct {
    logic                     operation;
    logic [TIME_W-1:0]        time_value;
    logic [3:0]               gain_index;
    logic signed [COEF_W-1:0] gain_value;
  } word_t;

  word_t                    word_feed[$];
  logic signed [COEF_W-1:0] pattern_due[$];

  // bench copy of the register file and feedback gains
  logic [PC_W-1:0]          count_mdl;
  logic signed [COEF_W-1:0] offset_mdl;
  logic [TERM_W-1:0]        term_mdl[MAX_TERMS];
  logic signed [COEF_W-1:0] gain_mdl[GAIN_DEPTH];

  int     errors = 0;
  int     n_eval = 0;
  int     n_gain = 0;
  int     n_cfg = 0;
  int     n_phase = 0;
  int     n_checked = 0;
  longint cycles = 0;
  logic   burst = 1'b0;      // stretch with no sender gaps
  logic   rx_burst = 1'b0;   // stretch with no receiver stalls
  logic   hold_go = 1'b0;
  logic   hold_done = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [15:0] clamp_q15(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // coefficient times its Q4.12 feedback gain, floored and saturated
  function automatic logic signed [15:0] with_gain(input int idx, input logic signed [15:0] c);
    longint g;
    g = (idx < GAIN_DEPTH) ? longint'(gain_mdl[idx]) : longint'(GAIN_ONE);
    return clamp_q15((longint'(c) * g) >>> 12);
  endfunction

  // 10^(F*octaves/2)/(2 pi) in Hz, Q32, via log2 and a short exp series
  function automatic logic [63:0] freq_hz_q32(input logic signed [15:0] fx);
    longint y, r, n, u, p, s;
    int k;
    y = ((longint'(fx) * FREQ_OCTAVES * LOG2_10_Q28) >>> 16) - LOG2_2PI_Q28;
    r = y & ((64'sd1 << 28) - 1);
    n = (y - r) >>> 28;
    u = (r * LN2_Q30_L) >>> 28;
    p = UNITY_Q30;
    for (k = 7; k >= 1; k--)
      p = UNITY_Q30 + ((u * p) >>> 30) / k;
    s = n + 2;
    if (s >= 0) begin
      if (s > 32) s = 32;
      return 64'(p) << s;
    end
    if (-s >= 63) return 64'd0;
    return 64'(p) >> (-s);
  endfunction

  // sine of an angle in turns (Q32), Q30 result
  function automatic longint sine_q30(input logic [31:0] ang);
    logic [63:0] w, z, z2, h, s;
    logic [63:0] dv[5];
    int i;
    dv = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    w = {34'd0, ang[29:0]};
    if (ang[30]) w = (64'd1 << 30) - w;
    z = (w * 64'(HALF_PI_Q30)) >> 30;
    z2 = (z * z) >> 30;
    h = 64'd1 << 30;
    for (i = 0; i < 5; i++)
      h = (64'd1 << 30) - ((z2 * h) >> 30) / dv[i];
    s = (z * h) >> 30;
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    return ang[31] ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic signed [15:0] pattern_at(input logic [TIME_W-1:0] tv);
    int terms, t;
    longint acc, den, q;
    logic signed [15:0] amp, fex, pha;
    logic [63:0] prod;
    logic [31:0] ang;
    if (count_mdl % 3 != 1) return '0;
    terms = (count_mdl - 1) / 3;
    if (terms > MAX_TERMS) return '0;
    acc = longint'(with_gain(0, offset_mdl)) * UNITY_Q30;
    for (t = 0; t < terms; t++) begin
      amp = with_gain(1 + 3 * t, term_mdl[t][15:0]);
      fex = with_gain(2 + 3 * t, term_mdl[t][31:16]);
      pha = with_gain(3 + 3 * t, term_mdl[t][47:32]);
      prod = freq_hz_q32(fex) * {32'd0, tv};
      ang = prod[47:16] + {pha, 16'h0000};
      acc += longint'(amp) * sine_q30(ang);
    end
    den = longint'(terms + 1) * UNITY_Q30;
    q = acc / den;
    if (acc % den != 0 && acc < 0) q--;
    return clamp_q15(q);
  endfunction

  // ---------------------------------------------------------------- sender

  int tx_gap = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_EVAL;
    in_ch.time_value = '0;
    in_ch.gain_index = '0;
    in_ch.gain_value = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the word until it is taken
    end else if (tx_gap > 0) begin
      tx_gap <= tx_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (word_feed.size() > 0) begin
      word_t w;
      w = word_feed.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.operation <= w.operation;
      in_ch.time_value <= w.time_value;
      in_ch.gain_index <= w.gain_index;
      in_ch.gain_value <= w.gain_value;
      tx_gap <= burst ? 0 : $urandom_range(0, 19);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // accepted words update the gain copy or queue a prediction
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      if (in_ch.operation == OP_GAIN) begin
        n_gain++;
        if (in_ch.gain_index < count_mdl && in_ch.gain_index < GAIN_DEPTH)
          gain_mdl[in_ch.gain_index] = in_ch.gain_value;
      end else begin
        n_eval++;
        pattern_due.push_back(pattern_at(in_ch.time_value));
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  int rx_stall = 0;
  int hold_cnt = 0;

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      // long hold so the block fills and stops taking input words
      hold_done <= 1'b1;
      hold_cnt <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      rx_stall <= rx_burst ? 0 : $urandom_range(0, 19);
      out_ch.ready <= rx_burst;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each pattern word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pattern_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected pattern word, actual %0d", $time, out_ch.pattern_value);
      end else begin
        logic signed [15:0] want;
        want = pattern_due.pop_front();
        n_checked++;
        if (out_ch.pattern_value !== want) begin
          errors++;
          $display("%0t: pattern_value mismatch, expected %0d actual %0d",
                   $time, want, out_ch.pattern_value);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d predictions outstanding",
               cycles, pattern_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [15:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'($signed($urandom_range(0, 4095)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'($urandom_range(0, 32'h0003_ffff));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return GAIN_ONE;
      3: return -GAIN_ONE;
      4: return 16'($signed($urandom_range(0, 16383)) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_eval(input logic [TIME_W-1:0] tv);
    word_t w;
    w.operation = OP_EVAL;
    w.time_value = tv;
    w.gain_index = 4'($urandom);
    w.gain_value = 16'($urandom);
    word_feed.push_back(w);
  endtask

  task automatic push_gain(input logic [3:0] idx, input logic signed [15:0] g);
    word_t w;
    w.operation = OP_GAIN;
    w.time_value = 32'($urandom);
    w.gain_index = idx;
    w.gain_value = g;
    word_feed.push_back(w);
  endtask

  // one register write, mirrored in the bench copy; gains go back to unity on listed indexes
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    n_cfg++;
    if (idx <= CFG_TERM3) begin
      case (idx)
        CFG_PARAM_COUNT: count_mdl = v[PC_W-1:0];
        CFG_OFFSET:      offset_mdl = v[COEF_W-1:0];
        default:         term_mdl[idx - CFG_TERM0] = v[TERM_W-1:0];
      endcase
      for (int i = 0; i < GAIN_DEPTH; i++) gain_mdl[i] = GAIN_ONE;
    end
  endtask

  task automatic reg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all words sent, all patterns seen, then a wait so a trailing gain write lands
  task automatic drain();
    do @(posedge clk);
    while (word_feed.size() > 0 || in_ch.valid || pattern_due.size() > 0);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [TERM_W-1:0] pick_term();
    return {pick_coef(), pick_coef(), pick_coef()};
  endfunction

  // weighted towards cheap term counts since each term adds a full pass through the series
  function automatic logic [PC_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 4'd1;
    if (r < 55) return 4'd4;
    if (r < 75) return 4'd7;
    if (r < 83) return 4'd10;
    if (r < 90) return 4'd13;
    return 4'($urandom);
  endfunction

  initial begin
    int sent;
    int n_items;
    logic [PC_W-1:0] pc;
    logic [PC_W-1:0] bad_counts[4];
    bad_counts = '{4'd0, 4'd2, 4'd14, 4'd15};
    count_mdl = 4'd1;
    offset_mdl = '0;
    for (int t = 0; t < MAX_TERMS; t++) term_mdl[t] = '0;
    for (int i = 0; i < GAIN_DEPTH; i++) gain_mdl[i] = GAIN_ONE;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset registers, offset only
    n_phase++;
    push_eval(32'h0000_0000);
    push_eval(32'hffff_ffff);
    push_gain(4'd0, 16'sh7fff);
    push_gain(4'd1, 16'sh1234);       // at or beyond count, ignored
    push_eval(32'h0001_0000);
    drain();

    // directed: mostly extreme coefficients in every term, largest count
    n_phase++;
    reg_write(CFG_OFFSET, CFG_DATA_W'(16'sh7fff));
    reg_write(CFG_TERM0, {16'sh0000, 16'sh8000, 16'sh7fff});
    reg_write(CFG_TERM1, {16'sh7fff, 16'sh7fff, 16'sh8000});
    reg_write(CFG_TERM2, {16'sh8000, 16'sh0000, 16'sh7fff});
    reg_write(CFG_TERM3, {16'sh4000, 16'sh2000, 16'sh7fff});
    reg_write(CFG_PARAM_COUNT, CFG_DATA_W'(4'd13));
    reg_done();
    push_eval(32'h0000_0000);
    push_eval(32'hffff_ffff);
    push_gain(4'd12, 16'sh8000);
    push_gain(4'd15, 16'sh7fff);      // beyond the store
    push_gain(4'd0, 16'sh8000);
    push_gain(4'd1, 16'sh7fff);
    push_eval(32'h0000_8000);
    drain();

    // directed: out-of-map register index keeps gains
    n_phase++;
    push_gain(4'd2, -GAIN_ONE);
    drain();
    reg_write(CFG_SPARE, {CFG_DATA_W{1'b1}});
    reg_write(CFG_SPARE + 3'd1, '0);
    reg_done();
    push_eval(32'h1234_5678);
    drain();

    // directed: unusable counts answer zero
    n_phase++;
    foreach (bad_counts[k]) begin
      reg_write(CFG_PARAM_COUNT, CFG_DATA_W'(bad_counts[k]));
      reg_done();
      push_eval(32'($urandom));
      drain();
    end

    // random phases, each with a fresh register set
    sent = 0;
    while (sent < N_RANDOM) begin
      n_phase++;
      burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      pc = pick_count();
      reg_write(CFG_OFFSET, CFG_DATA_W'(pick_coef()));
      reg_write(CFG_TERM0, pick_term());
      reg_write(CFG_TERM1, pick_term());
      reg_write(CFG_TERM2, pick_term());
      reg_write(CFG_TERM3, pick_term());
      if ($urandom_range(0, 5) == 0) reg_write(CFG_SPARE, CFG_DATA_W'({$urandom, $urandom}));
      reg_write(CFG_PARAM_COUNT, CFG_DATA_W'({$urandom, $urandom} & ~64'hf) | pc);
      reg_done();
      // long receiver hold once the run is under way
      if (!hold_done && sent > 300) hold_go <= 1'b1;
      n_items = $urandom_range(25, 55);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 99) < 55) begin
          push_eval(pick_time());
        end else if ($urandom_range(0, 4) == 0) begin
          push_gain(4'($urandom), pick_gain());
        end else begin
          push_gain(4'($urandom_range(0, (pc == 0) ? 0 : pc - 1)), pick_gain());
        end
      end
      sent += n_items;
      drain();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d phases: %0d evaluate and %0d gain-write words, %0d register writes",
             n_phase, n_eval, n_gain, n_cfg);
    $display("%0d pattern words checked, %0d errors", n_checked, errors);
    if (errors == 0 && pattern_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
